// File: sv/beb_pkg.sv
`default_nettype none
package beb_pkg;

  // Store geometry and field widths.
  localparam int DEPTH     = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = 6;
  localparam int COST_W    = 24;
  localparam int TOTAL_W   = 29;
  localparam int BUDGET_W  = 24;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 24'd8192;

  // Request modes.
  localparam logic [1:0] MODE_APPEND  = 2'd0;
  localparam logic [1:0] MODE_PREPEND = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  // Entry classes.
  localparam logic [1:0] CLS_SYSTEM    = 2'd0;
  localparam logic [1:0] CLS_USER      = 2'd1;
  localparam logic [1:0] CLS_ASSISTANT = 2'd2;
  localparam logic [1:0] CLS_TOOL      = 2'd3;

  // Result kinds and status codes.
  localparam logic KIND_EVICT  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic [2:0] ST_ADDED       = 3'd0;
  localparam logic [2:0] ST_ADDED_OVER  = 3'd1;
  localparam logic [2:0] ST_DROP_BUDGET = 3'd2;
  localparam logic [2:0] ST_DROP_FULL   = 3'd3;
  localparam logic [2:0] ST_CLEARED     = 3'd4;
  localparam logic [2:0] ST_PREPENDED   = 3'd5;

  typedef struct packed {
    logic [1:0]        mode;
    logic [1:0]        entry_class;
    logic [COST_W-1:0] entry_cost;
  } req_t;

  typedef struct packed {
    logic               item_kind;
    logic [1:0]         evicted_class;
    logic [COST_W-1:0]  evicted_cost;
    logic [2:0]         status;
    logic [TOTAL_W-1:0] total_after;
    logic [CNT_W-1:0]   count_after;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [1:0]        cls;
    logic [COST_W-1:0] cost;
  } entry_t;

  // Physical slot of the logical position i behind the head of the ring.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] i);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(i);
    if (s >= (CNT_W+1)'(DEPTH)) s = s - (CNT_W+1)'(DEPTH);
    return IDX_W'(s);
  endfunction

endpackage
`default_nettype wire

// File: sv/beb_if.sv
`default_nettype none
interface beb_req_if;
  logic          valid;
  logic          ready;
  beb_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface beb_res_if;
  logic          valid;
  logic          ready;
  beb_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface beb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [beb_pkg::BUDGET_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/budget_eviction_buffer.sv
`default_nettype none
// Channel   Dir  Payload                                   Handshake
// in_req    in   mode, entry_class, entry_cost            valid/ready
// out_res   out  kind, evicted class/cost, status, totals  valid/ready
// cfg_wr    in   token_budget                              valid/ready (always ready)
//
// Clear and prepend go through accept and status; an append without eviction goes through
// accept, check and status. Each eviction adds a scan of the stored entries through
// the memory read port, a pick step, a compaction of the entries behind the victim
// and a new check.
// Reset (rst_n low, synchronous) empties the store and loads the budget with 8192.
// A stalled result holds the machine at the next point where it must emit a result.
module budget_eviction_buffer (
  input  wire logic clk,
  input  wire logic rst_n,
  beb_req_if.sink   in_req,
  beb_res_if.source out_res,
  beb_cfg_if.sink   cfg_wr
);
  import beb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_MOVE  = 3'd4;
  localparam logic [2:0] S_STAT  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [BUDGET_W-1:0] budget_r;
  logic [1:0]          req_cls_r, req_cls_nxt;
  logic [COST_W-1:0]   req_cost_r, req_cost_nxt;
  logic [2:0]          stat_r, stat_nxt;
  logic [CNT_W-1:0]    scan_i_r, scan_i_nxt;
  logic                rd_v_r, rd_v_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                fu_r, ft_r, fa_r, fu_nxt, ft_nxt, fa_nxt;
  logic [CNT_W-1:0]    fu_idx_r, ft_idx_r, fa_idx_r, fu_idx_nxt, ft_idx_nxt, fa_idx_nxt;
  entry_t              fu_ent_r, ft_ent_r, fa_ent_r, fu_ent_nxt, ft_ent_nxt, fa_ent_nxt;
  logic                out_valid_r;
  res_t                out_r, out_nxt;
  logic                out_load, out_free;

  entry_t              mem [DEPTH];
  logic                wr_en, rd_en;
  logic [IDX_W-1:0]    wr_addr, rd_addr;
  entry_t              wr_data, rd_data;

  logic                over;
  logic                vic_any;
  logic [CNT_W-1:0]    vic_idx;
  entry_t              vic_ent;

  assign in_req.ready  = (state_r == S_IDLE);
  assign cfg_wr.ready  = 1'b1;
  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_r;
  assign out_free      = !out_valid_r || out_res.ready;

  // Budget test on the pending append.
  assign over = ({1'b0, total_r} + (TOTAL_W+1)'(req_cost_r)) > (TOTAL_W+1)'(budget_r);

  // Victim priority: user, then tool, then assistant.
  always_comb begin
    vic_any = fu_r || ft_r || fa_r;
    if (fu_r) begin
      vic_idx = fu_idx_r;
      vic_ent = fu_ent_r;
    end else if (ft_r) begin
      vic_idx = ft_idx_r;
      vic_ent = ft_ent_r;
    end else begin
      vic_idx = fa_idx_r;
      vic_ent = fa_ent_r;
    end
  end

  // Entry memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    total_nxt    = total_r;
    head_nxt     = head_r;
    req_cls_nxt  = req_cls_r;
    req_cost_nxt = req_cost_r;
    stat_nxt     = stat_r;
    scan_i_nxt   = scan_i_r;
    rd_v_nxt     = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    fu_nxt       = fu_r;
    ft_nxt       = ft_r;
    fa_nxt       = fa_r;
    fu_idx_nxt   = fu_idx_r;
    ft_idx_nxt   = ft_idx_r;
    fa_idx_nxt   = fa_idx_r;
    fu_ent_nxt   = fu_ent_r;
    ft_ent_nxt   = ft_ent_r;
    fa_ent_nxt   = fa_ent_r;
    out_load     = 1'b0;
    out_nxt      = out_r;
    wr_en        = 1'b0;
    wr_addr      = head_r;
    wr_data      = '0;
    rd_en        = 1'b0;
    rd_addr      = head_r;

    // Scan results come back in the cycle after the read.
    if (state_r == S_SCAN && rd_v_r) begin
      if (rd_data.cls == CLS_USER && !fu_r) begin
        fu_nxt     = 1'b1;
        fu_idx_nxt = rd_idx_r;
        fu_ent_nxt = rd_data;
      end
      if (rd_data.cls == CLS_TOOL && !ft_r) begin
        ft_nxt     = 1'b1;
        ft_idx_nxt = rd_idx_r;
        ft_ent_nxt = rd_data;
      end
      if (rd_data.cls == CLS_ASSISTANT && !fa_r) begin
        fa_nxt     = 1'b1;
        fa_idx_nxt = rd_idx_r;
        fa_ent_nxt = rd_data;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          case (in_req.data.mode)
            MODE_CLEAR: begin
              cnt_nxt   = '0;
              total_nxt = '0;
              stat_nxt  = ST_CLEARED;
              state_nxt = S_STAT;
            end
            MODE_PREPEND: begin
              if (cnt_r >= CNT_W'(DEPTH)) begin
                stat_nxt = ST_DROP_FULL;
              end else begin
                head_nxt     = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - IDX_W'(1);
                wr_en        = 1'b1;
                wr_addr      = head_nxt;
                wr_data.cls  = CLS_SYSTEM;
                wr_data.cost = in_req.data.entry_cost;
                cnt_nxt      = cnt_r + CNT_W'(1);
                total_nxt    = total_r + TOTAL_W'(in_req.data.entry_cost);
                stat_nxt     = ST_PREPENDED;
              end
              state_nxt = S_STAT;
            end
            MODE_APPEND: begin
              req_cls_nxt  = in_req.data.entry_class;
              req_cost_nxt = in_req.data.entry_cost;
              state_nxt    = S_CHECK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (cnt_r != '0 && over) begin
          scan_i_nxt = '0;
          fu_nxt     = 1'b0;
          ft_nxt     = 1'b0;
          fa_nxt     = 1'b0;
          state_nxt  = S_SCAN;
        end else if (cnt_r >= CNT_W'(DEPTH)) begin
          stat_nxt  = ST_DROP_FULL;
          state_nxt = S_STAT;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = phys(head_r, cnt_r);
          wr_data.cls  = req_cls_r;
          wr_data.cost = req_cost_r;
          cnt_nxt      = cnt_r + CNT_W'(1);
          total_nxt    = total_r + TOTAL_W'(req_cost_r);
          stat_nxt     = over ? ST_ADDED_OVER : ST_ADDED;
          state_nxt    = S_STAT;
        end
      end
      S_SCAN: begin
        if (scan_i_r < cnt_r) begin
          rd_en      = 1'b1;
          rd_addr    = phys(head_r, scan_i_r);
          rd_v_nxt   = 1'b1;
          rd_idx_nxt = scan_i_r;
          scan_i_nxt = scan_i_r + CNT_W'(1);
        end else if (!rd_v_r) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (!vic_any) begin
          stat_nxt  = ST_DROP_BUDGET;
          state_nxt = S_STAT;
        end else if (out_free) begin
          out_load              = 1'b1;
          out_nxt.item_kind     = KIND_EVICT;
          out_nxt.evicted_class = vic_ent.cls;
          out_nxt.evicted_cost  = vic_ent.cost;
          out_nxt.status        = ST_ADDED;
          out_nxt.total_after   = total_r - TOTAL_W'(vic_ent.cost);
          out_nxt.count_after   = cnt_r - CNT_W'(1);
          out_nxt.last          = 1'b0;
          total_nxt             = total_r - TOTAL_W'(vic_ent.cost);
          cnt_nxt               = cnt_r - CNT_W'(1);
          scan_i_nxt            = vic_idx + CNT_W'(1);
          state_nxt             = S_MOVE;
        end
      end
      S_MOVE: begin
        // Entries behind the victim move up one place, read ahead of the write.
        if (rd_v_r) begin
          wr_en   = 1'b1;
          wr_addr = phys(head_r, rd_idx_r - CNT_W'(1));
          wr_data = rd_data;
        end
        if (scan_i_r <= cnt_r) begin
          rd_en      = 1'b1;
          rd_addr    = phys(head_r, scan_i_r);
          rd_v_nxt   = 1'b1;
          rd_idx_nxt = scan_i_r;
          scan_i_nxt = scan_i_r + CNT_W'(1);
        end else if (!rd_v_r) begin
          state_nxt = S_CHECK;
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_nxt.item_kind     = KIND_STATUS;
          out_nxt.evicted_class = CLS_SYSTEM;
          out_nxt.evicted_cost  = '0;
          out_nxt.status        = stat_r;
          out_nxt.total_after   = total_r;
          out_nxt.count_after   = cnt_r;
          out_nxt.last          = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      total_r     <= '0;
      head_r      <= '0;
      budget_r    <= BUDGET_RESET;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      head_r  <= head_nxt;
      rd_v_r  <= rd_v_nxt;
      if (cfg_wr.valid) budget_r <= cfg_wr.data;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_res.ready) out_valid_r <= 1'b0;
    end
  end

  // Request and scan payload.
  always_ff @(posedge clk) begin
    req_cls_r  <= req_cls_nxt;
    req_cost_r <= req_cost_nxt;
    stat_r     <= stat_nxt;
    scan_i_r   <= scan_i_nxt;
    rd_idx_r   <= rd_idx_nxt;
    fu_r       <= fu_nxt;
    ft_r       <= ft_nxt;
    fa_r       <= fa_nxt;
    fu_idx_r   <= fu_idx_nxt;
    ft_idx_r   <= ft_idx_nxt;
    fa_idx_r   <= fa_idx_nxt;
    fu_ent_r   <= fu_ent_nxt;
    ft_ent_r   <= ft_ent_nxt;
    fa_ent_r   <= fa_ent_nxt;
    out_r      <= out_nxt;
  end

endmodule
`default_nettype wire

// File: sim/beb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module beb_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  beb_req_if.sink   mon_req,
  beb_res_if.sink   mon_res,
  beb_cfg_if.sink   mon_cfg,
  output int        fail_count,
  output int        pending
);
  import beb_pkg::*;

  logic [BUDGET_W-1:0] budget;
  logic [1:0]          cls_q[$];
  logic [COST_W-1:0]   cost_q[$];
  logic [TOTAL_W-1:0]  total;
  res_t                expected_results[$];

  assign pending = expected_results.size();

  // Queue one result item built from the current store totals.
  task automatic push_result(input logic kind, input logic [1:0] cls,
                             input logic [COST_W-1:0] cost, input logic [2:0] st,
                             input logic lst);
    res_t r;
    r.item_kind     = kind;
    r.evicted_class = cls;
    r.evicted_cost  = cost;
    r.status        = st;
    r.total_after   = total;
    r.count_after   = CNT_W'(cls_q.size());
    r.last          = lst;
    expected_results.insert(expected_results.size(), r);
  endtask

  // Index of the oldest entry of a class, or -1.
  function automatic int oldest_of(input logic [1:0] c);
    foreach (cls_q[i]) if (cls_q[i] == c) return i;
    return -1;
  endfunction

  // Apply one request to the store model and queue its results.
  task automatic apply_request(input req_t rq);
    int v;
    logic [1:0] ec;
    logic [COST_W-1:0] ecost;
    logic over;
    if (rq.mode == MODE_CLEAR) begin
      cls_q.delete();
      cost_q.delete();
      total = '0;
      push_result(KIND_STATUS, CLS_SYSTEM, '0, ST_CLEARED, 1'b1);
    end else if (rq.mode == MODE_PREPEND) begin
      if (cls_q.size() >= DEPTH) begin
        push_result(KIND_STATUS, CLS_SYSTEM, '0, ST_DROP_FULL, 1'b1);
      end else begin
        cls_q.insert(0, CLS_SYSTEM);
        cost_q.insert(0, rq.entry_cost);
        total = total + TOTAL_W'(rq.entry_cost);
        push_result(KIND_STATUS, CLS_SYSTEM, '0, ST_PREPENDED, 1'b1);
      end
    end else if (rq.mode == MODE_APPEND) begin
      // Evict by priority: user, then tool, then assistant.
      while (cls_q.size() > 0 &&
             (64'(total) + 64'(rq.entry_cost) > 64'(budget))) begin
        v = oldest_of(CLS_USER);
        if (v < 0) v = oldest_of(CLS_TOOL);
        if (v < 0) v = oldest_of(CLS_ASSISTANT);
        if (v < 0) break;
        ec = cls_q[v];
        ecost = cost_q[v];
        cls_q.delete(v);
        cost_q.delete(v);
        total = total - TOTAL_W'(ecost);
        push_result(KIND_EVICT, ec, ecost, ST_ADDED, 1'b0);
      end
      over = (64'(total) + 64'(rq.entry_cost) > 64'(budget));
      if (cls_q.size() > 0 && over) begin
        push_result(KIND_STATUS, CLS_SYSTEM, '0, ST_DROP_BUDGET, 1'b1);
      end else if (cls_q.size() >= DEPTH) begin
        push_result(KIND_STATUS, CLS_SYSTEM, '0, ST_DROP_FULL, 1'b1);
      end else begin
        cls_q.insert(cls_q.size(), rq.entry_class);
        cost_q.insert(cost_q.size(), rq.entry_cost);
        total = total + TOTAL_W'(rq.entry_cost);
        push_result(KIND_STATUS, CLS_SYSTEM, '0, over ? ST_ADDED_OVER : ST_ADDED, 1'b1);
      end
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Watch all channels at each edge.
  always @(posedge clk) begin
    res_t e;
    res_t g;
    if (!rst_n) begin
      budget = BUDGET_RESET;
      cls_q.delete();
      cost_q.delete();
      total = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (mon_cfg.valid && mon_cfg.ready) budget = mon_cfg.data;
      if (mon_res.valid && mon_res.ready) begin
        g = mon_res.data;
        if (expected_results.size() == 0) begin
          report("unexpected result", 64'(g), 64'd0);
        end else begin
          e = expected_results.pop_front();
          if (g.item_kind != e.item_kind) report("item_kind", g.item_kind, e.item_kind);
          if (g.evicted_class != e.evicted_class)
            report("evicted_class", g.evicted_class, e.evicted_class);
          if (g.evicted_cost != e.evicted_cost)
            report("evicted_cost", g.evicted_cost, e.evicted_cost);
          if (g.status != e.status) report("status", g.status, e.status);
          if (g.total_after != e.total_after)
            report("total_after", g.total_after, e.total_after);
          if (g.count_after != e.count_after)
            report("count_after", g.count_after, e.count_after);
          if (g.last != e.last) report("last", g.last, e.last);
        end
      end
      if (mon_req.valid && mon_req.ready) apply_request(mon_req.data);
    end
  end
endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import beb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_REQUESTS = 160;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  logic calm;
  int   req_gap;
  int   res_gap;

  beb_req_if req_ch();
  beb_res_if res_ch();
  beb_cfg_if cfg_ch();

  budget_eviction_buffer DUT (
    .clk(clk), .rst_n(rst_n), .in_req(req_ch.sink), .out_res(res_ch.source),
    .cfg_wr(cfg_ch.sink)
  );

  beb_checker checker_i (
    .clk(clk), .rst_n(rst_n), .mon_req(req_ch.sink), .mon_res(res_ch.sink),
    .mon_cfg(cfg_ch.sink), .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    calm = 1'b0;
  end

  // Result side stalls in random bursts except in the calm tail.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_gap <= 0;
      res_ch.ready <= 1'b0;
    end else if (res_gap > 0) begin
      res_gap <= res_gap - 1;
      res_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      res_gap <= $urandom_range(1, 15);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no accepted transfer.
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Valid stays high after the accepting edge; the next request reuses or drops it, or a drain takes it down.
  task automatic send_request(input logic [1:0] m, input logic [1:0] c,
                              input logic [COST_W-1:0] cost);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_gap = $urandom_range(1, 15);
      req_ch.valid <= 1'b0;
      repeat (req_gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= '{mode: m, entry_class: c, entry_cost: cost};
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_budget(input logic [BUDGET_W-1:0] b);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= b;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random append with a cost scaled to the budget, or other modes.
  task automatic random_request(input int scale);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      send_request(MODE_APPEND, 2'($urandom_range(0, 3)), COST_W'($urandom_range(0, scale)));
    else if (pick < 85)
      send_request(MODE_PREPEND, 2'($urandom), COST_W'($urandom_range(0, scale / 4)));
    else if (pick < 90)
      send_request(MODE_CLEAR, 2'($urandom), COST_W'($urandom));
    else if (pick < 93)
      send_request(2'd3, 2'($urandom), COST_W'($urandom));
    else
      send_request(MODE_APPEND, 2'($urandom), COST_W'($urandom));
  endtask

  initial begin
    int i;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fill, evict by priority, system-only drop, empty-store add.
    send_request(MODE_APPEND, CLS_USER, 24'd1000);
    send_request(MODE_APPEND, CLS_TOOL, 24'd2000);
    send_request(MODE_APPEND, CLS_ASSISTANT, 24'd3000);
    send_request(MODE_APPEND, CLS_USER, 24'd1500);
    send_request(MODE_PREPEND, CLS_USER, 24'd500);
    send_request(MODE_APPEND, CLS_SYSTEM, 24'd7000);
    send_request(MODE_APPEND, CLS_TOOL, 24'd8000);
    send_request(MODE_APPEND, CLS_USER, 24'hFFFFFF);
    send_request(MODE_CLEAR, CLS_TOOL, 24'hFFFFFF);
    send_request(MODE_APPEND, CLS_ASSISTANT, 24'hFFFFFF);
    send_request(MODE_APPEND, CLS_USER, 24'd0);
    send_request(2'd3, CLS_TOOL, 24'hABCDEF);
    send_request(MODE_CLEAR, CLS_SYSTEM, 24'd0);
    // Sender holds until all results are back.
    drain();

    // Full store: zero costs never exceed the budget.
    write_budget(24'd0);
    for (i = 0; i < DEPTH; i++) send_request(MODE_APPEND, 2'(i), 24'd0);
    send_request(MODE_APPEND, CLS_USER, 24'd0);
    send_request(MODE_PREPEND, CLS_USER, 24'd0);
    send_request(MODE_APPEND, CLS_USER, 24'd1);
    send_request(MODE_CLEAR, CLS_USER, 24'd0);

    // Random phases at several budgets, extremes among them.
    write_budget(24'hFFFFFF);
    for (i = 0; i < 25; i++) random_request(24'hFFFFFF >> 3);
    write_budget(24'd100);
    for (i = 0; i < 25; i++) random_request(40);
    write_budget(24'd0);
    for (i = 0; i < 15; i++) random_request(3);
    write_budget(BUDGET_RESET);
    for (i = 0; i < 25; i++) random_request(3000);
    calm = 1'b1;
    for (i = 0; i < RANDOM_REQUESTS - 140; i++) random_request(3000);

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
